// File: rtl/ibmw_pkg.sv
// Shared types, codes and address helpers for the indirect block map walker.
// No dependencies; every other source file but ibmw_ptr_mem imports this package.
package ibmw_pkg;

   localparam int ADDR_W    = 48;
   localparam int BLK_W     = 32;
   localparam int LBLK_W    = 32;
   localparam int SLOT_W    = 4;
   localparam int SHIFT_W   = 5;
   localparam int ISH_W     = 4;
   localparam int SHAMT_W   = 6;
   localparam int LEVEL_W   = 2;

   localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd10;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd10;
   // bytes in one pointer word, as log2
   localparam logic [SHIFT_W-1:0] WORD_LOG    = 5'd2;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_START = 2'd1,
      ACT_WORD  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_RANGE = 2'd2,
      KIND_RSVD  = 2'd3
   } kind_type;

   // Decoded item handed from the decode stage to the walk stage.
   typedef struct packed {
      action_type           action;
      logic [BLK_W-1:0]     value;
      logic                 direct;
      logic                 range_err;
      logic [LEVEL_W-1:0]   level;
      logic [LBLK_W-1:0]    rel;
   } dec_type;

   // Clamp the block size shift into its legal range.
   function automatic logic [SHIFT_W-1:0] eff_shift(input logic [SHIFT_W-1:0] shift);
      logic [SHIFT_W-1:0] s;
      s = shift;
      if (s < SHIFT_MIN) s = SHIFT_MIN;
      if (s > SHIFT_MAX) s = SHIFT_MAX;
      return s;
   endfunction

   // log2 of pointer words per block.
   function automatic logic [ISH_W-1:0] index_shift(input logic [SHIFT_W-1:0] shift);
      logic [SHIFT_W-1:0] d;
      d = eff_shift(shift) - WORD_LOG;
      return d[ISH_W-1:0];
   endfunction

   // Byte address of the pointer word of a level inside block blk.
   function automatic logic [ADDR_W-1:0] word_addr(input logic [BLK_W-1:0]   blk,
                                                  input logic [LBLK_W-1:0]  rel,
                                                  input logic [LEVEL_W-1:0] lvl,
                                                  input logic [SHIFT_W-1:0] shift);
      logic [SHIFT_W-1:0] s;
      logic [ISH_W-1:0]   ish;
      logic [SHAMT_W-1:0] shamt;
      logic [LBLK_W-1:0]  idx;
      logic [ADDR_W-1:0]  base;
      s     = eff_shift(shift);
      ish   = index_shift(shift);
      shamt = SHAMT_W'(ish) * SHAMT_W'(lvl);
      idx   = (rel >> shamt) & ((LBLK_W'(1) << ish) - LBLK_W'(1));
      base  = {{(ADDR_W-BLK_W){1'b0}}, blk} << s;
      return base + {{(ADDR_W-LBLK_W-2){1'b0}}, idx, 2'b00};
   endfunction

endpackage

// File: rtl/ibmw_ptr_mem.sv
// Pointer table memory: one write port, one registered read port.
// Per-entry valid bits give the zero reset value. Depends on nothing.
module ibmw_ptr_mem #(
   parameter  int DEPTH  = 15,
   parameter  int DATA_W = 32,
   localparam int AW     = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ibmw_decode.sv
// Decode stage: picks the table slot and indirection level of an item.
// Depends on ibmw_pkg.
module ibmw_decode #(
   parameter  int DIRECT_POINTERS = 12,
   parameter  int INDIRECT_LEVELS = 3,
   localparam int SLOTS           = DIRECT_POINTERS + INDIRECT_LEVELS,
   localparam int AW              = $clog2(SLOTS)
) (
   input  logic [1:0]                     req_action,
   input  logic [ibmw_pkg::SLOT_W-1:0]    req_slot,
   input  logic [ibmw_pkg::BLK_W-1:0]     req_value,
   input  logic [ibmw_pkg::LBLK_W-1:0]    req_logical_block,
   input  logic [ibmw_pkg::SHIFT_W-1:0]   shift,
   output ibmw_pkg::dec_type              dec,
   output logic                           wr_en,
   output logic [AW-1:0]                  wr_addr,
   output logic                           rd_en,
   output logic [AW-1:0]                  rd_addr
);
   import ibmw_pkg::*;

   localparam int SLOT_CW = SLOT_W + 1;

   logic [ISH_W-1:0]   ish;
   logic [ADDR_W-1:0]  cum;
   logic [ADDR_W-1:0]  prev;
   logic [ADDR_W-1:0]  base;
   logic [SHAMT_W-1:0] shamt;
   logic               found;
   logic [LEVEL_W-1:0] lvl;
   logic               direct;
   logic [LBLK_W-1:0]  rel;
   action_type         act;

   assign act    = action_type'(req_action);
   assign ish    = index_shift(shift);
   assign direct = req_logical_block < LBLK_W'(DIRECT_POINTERS);
   assign rel    = req_logical_block - LBLK_W'(DIRECT_POINTERS);

   // Level ranges span 2^ish, 2^(2 ish), 2^(3 ish) blocks; first one that holds rel wins.
   always_comb begin
      cum   = '0;
      prev  = '0;
      base  = '0;
      shamt = '0;
      found = 1'b0;
      lvl   = '0;
      for (int lv = 0; lv < INDIRECT_LEVELS; lv++) begin
         prev  = cum;
         shamt = SHAMT_W'(ish) * SHAMT_W'(lv + 1);
         cum   = cum + (ADDR_W'(1) << shamt);
         if (!found && ({{(ADDR_W-LBLK_W){1'b0}}, rel} < cum)) begin
            found = 1'b1;
            lvl   = LEVEL_W'(lv);
            base  = prev;
         end
      end
   end

   always_comb begin
      dec.action    = act;
      dec.value     = req_value;
      dec.direct    = direct;
      dec.range_err = !direct && !found;
      dec.level     = lvl;
      dec.rel       = rel - base[LBLK_W-1:0];
   end

   assign wr_en   = (act == ACT_LOAD) && ({1'b0, req_slot} < SLOT_CW'(SLOTS));
   assign wr_addr = AW'({1'b0, req_slot});
   assign rd_en   = (act == ACT_START);
   assign rd_addr = direct ? req_logical_block[AW-1:0]
                           : AW'(DIRECT_POINTERS) + AW'(lvl);

endmodule

// File: rtl/ibmw_walk.sv
// Walk stage: holds the walk state, forms at most one result per item and drives the
// output register. Depends on ibmw_pkg.
module ibmw_walk (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  ibmw_pkg::dec_type              dec,
   input  logic [ibmw_pkg::BLK_W-1:0]     table_data,
   input  logic [ibmw_pkg::SHIFT_W-1:0]   shift,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_kind,
   output logic [ibmw_pkg::ADDR_W-1:0]    rsp_read_address,
   output logic [ibmw_pkg::BLK_W-1:0]     rsp_physical_block
);
   import ibmw_pkg::*;

   logic               s1_valid_ff;
   dec_type            s1_ff;
   logic               busy_ff, busy_in;
   logic [LEVEL_W-1:0] levels_ff, levels_in;
   logic [LBLK_W-1:0]  rel_ff, rel_in;

   logic               out_valid_ff;
   kind_type           out_kind_ff;
   logic [ADDR_W-1:0]  out_addr_ff;
   logic [BLK_W-1:0]   out_blk_ff;

   logic               has_res;
   kind_type           kind;
   logic [BLK_W-1:0]   res_blk;
   logic [BLK_W-1:0]   rd_blk;
   logic [LEVEL_W-1:0] rd_lvl;
   logic [LBLK_W-1:0]  rd_rel;
   logic [ADDR_W-1:0]  res_addr;
   logic               out_free;
   logic               s1_fire;

   always_comb begin
      has_res   = 1'b0;
      kind      = KIND_DONE;
      res_blk   = '0;
      rd_blk    = '0;
      rd_lvl    = '0;
      rd_rel    = rel_ff;
      busy_in   = busy_ff;
      levels_in = levels_ff;
      rel_in    = rel_ff;
      unique case (s1_ff.action)
         ACT_START: begin
            busy_in   = 1'b0;
            levels_in = '0;
            has_res   = 1'b1;
            if (s1_ff.direct) begin
               res_blk = table_data;
            end else if (s1_ff.range_err) begin
               kind = KIND_RANGE;
            end else begin
               rel_in = s1_ff.rel;
               if (table_data != '0) begin
                  busy_in   = 1'b1;
                  levels_in = s1_ff.level;
                  kind      = KIND_READ;
                  rd_blk    = table_data;
                  rd_lvl    = s1_ff.level;
                  rd_rel    = s1_ff.rel;
               end
            end
         end
         ACT_WORD: begin
            if (busy_ff) begin
               has_res = 1'b1;
               if (levels_ff == '0 || s1_ff.value == '0) begin
                  busy_in   = 1'b0;
                  levels_in = '0;
                  res_blk   = s1_ff.value;
               end else begin
                  levels_in = levels_ff - LEVEL_W'(1);
                  kind      = KIND_READ;
                  rd_blk    = s1_ff.value;
                  rd_lvl    = levels_ff - LEVEL_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign res_addr = (kind == KIND_READ) ? word_addr(rd_blk, rd_rel, rd_lvl, shift) : '0;

   // Items with no result retire without needing output space.
   assign out_free = !out_valid_ff || rsp_ready;
   assign s1_fire  = s1_valid_ff && (!has_res || out_free);
   assign in_ready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s1_ff <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         levels_ff <= '0;
         rel_ff    <= '0;
      end else if (s1_fire) begin
         busy_ff   <= busy_in;
         levels_ff <= levels_in;
         rel_ff    <= rel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_fire && has_res) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && has_res) begin
         out_kind_ff <= kind;
         out_addr_ff <= res_addr;
         out_blk_ff  <= res_blk;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_read_address   = out_addr_ff;
   assign rsp_physical_block = out_blk_ff;

endmodule

// File: rtl/indirect_block_map_walker.sv
// Top level of the indirect block map walker: config register, pointer table,
// decode and walk stages. Depends on ibmw_pkg, ibmw_ptr_mem, ibmw_decode, ibmw_walk.
//
// Usage:
//   req_* carries one item per transfer: load a pointer slot, start a lookup of a
//   logical block, or hand back a pointer word that an earlier read request asked for.
//   rsp_* returns at most one result per item: a read request with the byte
//   address of the next pointer word, a finished lookup (block 0 marks a hole),
//   or an out of range error. Loads, unused actions and words with no walk in
//   flight give no result.
//   csr_* writes block_size_shift (log2 of the block size, clamped to 10..16);
//   write it only while the block is idle.
// Path: the table read and the decoded item are registered together at the item's
//   transfer; the walk step then writes the result into the output register.
// Throughput: one item per cycle while the walk stage is not held by a full output
//   register; set by the registered table read and the one-step walk update.
// Reset: the table reads as all zero, no walk is in flight, shift is 10.
// Stall: while rsp_ready is low the walk stage still takes one more item with a result
//   and holds it; items that produce no result keep flowing through it until then.
module indirect_block_map_walker #(
   parameter int DIRECT_POINTERS = 12,
   parameter int INDIRECT_LEVELS = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   // item channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_action,
   input  logic [ibmw_pkg::SLOT_W-1:0]    req_slot,
   input  logic [ibmw_pkg::BLK_W-1:0]     req_value,
   input  logic [ibmw_pkg::LBLK_W-1:0]    req_logical_block,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_kind,
   output logic [ibmw_pkg::ADDR_W-1:0]    rsp_read_address,
   output logic [ibmw_pkg::BLK_W-1:0]     rsp_physical_block,
   // config channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ibmw_pkg::SHIFT_W-1:0]   csr_wdata
);
   import ibmw_pkg::*;

   localparam int SLOTS = DIRECT_POINTERS + INDIRECT_LEVELS;
   localparam int AW    = $clog2(SLOTS);

   logic [SHIFT_W-1:0] shift_ff;
   dec_type            dec;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [BLK_W-1:0]   table_data;
   logic               req_xfer;

   // Config is always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_RESET;
      end else if (csr_valid) begin
         shift_ff <= csr_wdata;
      end
   end

   assign req_xfer = req_valid && req_ready;

   ibmw_decode #(
      .DIRECT_POINTERS (DIRECT_POINTERS),
      .INDIRECT_LEVELS (INDIRECT_LEVELS)
   ) u_decode (
      .req_action        (req_action),
      .req_slot          (req_slot),
      .req_value         (req_value),
      .req_logical_block (req_logical_block),
      .shift             (shift_ff),
      .dec               (dec),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr)
   );

   // Loads write and starts read at their own transfer edge, so program
   // order in the table is kept without forwarding.
   ibmw_ptr_mem #(
      .DEPTH  (SLOTS),
      .DATA_W (BLK_W)
   ) u_ptr_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_xfer && wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (req_xfer && rd_en),
      .rd_addr (rd_addr),
      .rd_data (table_data)
   );

   ibmw_walk u_walk (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (req_valid),
      .in_ready           (req_ready),
      .dec                (dec),
      .table_data         (table_data),
      .shift              (shift_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_read_address   (rsp_read_address),
      .rsp_physical_block (rsp_physical_block)
   );

   // Only the read request carries an address.
   a_addr_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_READ) |-> rsp_read_address == '0)
      else $error("read address set on a non-read result");

   // Only a finished lookup carries a block.
   a_blk_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_DONE) |-> rsp_physical_block == '0)
      else $error("physical block set on a non-done result");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind != KIND_RSVD)
      else $error("reserved result kind");

   // Reset flushes both stages.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

endmodule

// File: tb/indirect_block_map_walker_tb.sv
// Self-checking testbench for indirect_block_map_walker: directed and random lookups
// checked against an in-bench model of the block map walk.
// Depends on ibmw_pkg and the indirect_block_map_walker RTL.
module indirect_block_map_walker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ibmw_pkg::*;

   localparam int DIRECT_SLOTS    = 12;
   localparam int INDIRECT_DEPTH  = 3;
   localparam int TABLE_DEPTH     = DIRECT_SLOTS + INDIRECT_DEPTH;
   // two-stage pipeline; leave some margin after the last result
   localparam int DRAIN_CYCLES    = 8;
   localparam int ITEMS_PER_PHASE = 40;
   localparam int PHASE_COUNT     = 10;

   typedef struct {
      kind_type           kind;
      logic [ADDR_W-1:0]  addr;
      logic [BLK_W-1:0]   blk;
   } walk_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_action = ACT_NONE;
   logic [SLOT_W-1:0]    req_slot = '0;
   logic [BLK_W-1:0]     req_value = '0;
   logic [LBLK_W-1:0]    req_logical_block = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_kind;
   logic [ADDR_W-1:0]    rsp_read_address;
   logic [BLK_W-1:0]     rsp_physical_block;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [SHIFT_W-1:0]   csr_wdata = '0;

   // Model state: pointer table, walk progress and the current shift setting.
   logic [BLK_W-1:0]     ptr_slots [TABLE_DEPTH];
   bit                   walk_on = 1'b0;
   int unsigned          reads_left = 0;
   logic [63:0]          walk_rel = '0;
   logic [SHIFT_W-1:0]   cur_shift = SHIFT_RESET;

   walk_result_type      due_results [$];
   walk_result_type      got;
   int                   fails = 0;
   bit                   no_idle = 1'b0;
   int unsigned          rsp_hold = 0;
   int unsigned          hold_draw;

   indirect_block_map_walker #(
      .DIRECT_POINTERS (DIRECT_SLOTS),
      .INDIRECT_LEVELS (INDIRECT_DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_slot           (req_slot),
      .req_value          (req_value),
      .req_logical_block  (req_logical_block),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_read_address   (rsp_read_address),
      .rsp_physical_block (rsp_physical_block),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   // Wait drawn per item or per result; zero in stretches with idling off.
   function automatic int unsigned draw_gap();
      if (no_idle) return 0;
      return $urandom_range(0, 15);
   endfunction

   // Saturate the shift the way the block does before using it.
   function automatic int unsigned clamp_shift(input logic [SHIFT_W-1:0] s);
      if (s < 5'd10) return 10;
      if (s > 5'd16) return 16;
      return 32'(s);
   endfunction

   // Byte address of the pointer word for level lvl inside block blk.
   function automatic logic [ADDR_W-1:0] pointer_word_addr(input logic [BLK_W-1:0] blk,
                                                           input int unsigned lvl);
      int unsigned s, ish;
      logic [63:0] idx, a;
      s   = clamp_shift(cur_shift);
      ish = s - 2;
      idx = (walk_rel >> (ish * lvl)) & ((64'd1 << ish) - 64'd1);
      a   = ({32'd0, blk} << s) + (idx << 2);
      return a[ADDR_W-1:0];
   endfunction

   // Advance the model by one accepted item and queue the result it causes, if any.
   function automatic void block_map_step(input action_type act, input logic [SLOT_W-1:0] slot,
                                          input logic [BLK_W-1:0] value,
                                          input logic [LBLK_W-1:0] lblk);
      walk_result_type res;
      logic [63:0]     span, rel;
      int unsigned     ish, level;
      logic [BLK_W-1:0] root;
      bit              produced;
      produced = 1'b0;
      res.kind = KIND_READ;
      res.addr = '0;
      res.blk  = '0;
      case (act)
         ACT_LOAD: begin
            // slot 15 lies past the table: drop it
            if (slot < TABLE_DEPTH) ptr_slots[slot] = value;
         end
         ACT_START: begin
            // a new lookup always drops any walk in flight
            ish        = clamp_shift(cur_shift) - 2;
            span       = 64'd1 << ish;
            walk_on    = 1'b0;
            reads_left = 0;
            produced   = 1'b1;
            if (lblk < DIRECT_SLOTS) begin
               res.kind = KIND_DONE;
               res.blk  = ptr_slots[lblk[SLOT_W-1:0]];
            end else begin
               rel   = {32'd0, lblk} - 64'(DIRECT_SLOTS);
               level = 0;
               while (level < INDIRECT_DEPTH && rel >= span) begin
                  rel   = rel - span;
                  span  = span << ish;
                  level = level + 1;
               end
               if (level >= INDIRECT_DEPTH) begin
                  res.kind = KIND_RANGE;
               end else begin
                  root     = ptr_slots[DIRECT_SLOTS + level];
                  walk_rel = rel;
                  if (root == '0) begin
                     res.kind = KIND_DONE;
                  end else begin
                     walk_on    = 1'b1;
                     reads_left = level;
                     res.addr   = pointer_word_addr(root, level);
                  end
               end
            end
         end
         ACT_WORD: begin
            // a word with no walk in flight is dropped silently
            if (walk_on) begin
               produced = 1'b1;
               if (reads_left == 0 || value == '0) begin
                  walk_on    = 1'b0;
                  reads_left = 0;
                  res.kind   = KIND_DONE;
                  res.blk    = value;
               end else begin
                  reads_left = reads_left - 1;
                  res.addr   = pointer_word_addr(value, reads_left);
               end
            end
         end
         default: ;
      endcase
      if (produced) due_results.push_back(res);
   endfunction

   // Send one item: idle for a drawn gap, hold valid until the transfer, then
   // advance the model. Valid is lowered only at the start of a nonzero gap, so a
   // back-to-back item never sees valid dropped and raised in one step.
   task automatic send_item(input action_type act, input logic [SLOT_W-1:0] slot,
                            input logic [BLK_W-1:0] value, input logic [LBLK_W-1:0] lblk);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_slot          <= slot;
      req_value         <= value;
      req_logical_block <= lblk;
      do @(posedge clock); while (!req_ready);
      block_map_step(act, slot, value, lblk);
   endtask

   // Drain the pipeline: every due result back, then a few spare cycles so that
   // items with no result have also left the block.
   task automatic settle_walk();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write block_size_shift while the block is idle.
   task automatic write_block_shift(input logic [SHIFT_W-1:0] v);
      settle_walk();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_shift = v;
   endtask

   // Pick a logical block aimed at one of the ranges: direct, single, double,
   // triple or beyond, with the range edges drawn often.
   function automatic logic [LBLK_W-1:0] pick_logical_block();
      logic [63:0] base, span, limit, off, v;
      int unsigned ish, cls, lvl, i, edge_roll;
      ish = clamp_shift(cur_shift) - 2;
      cls = $urandom_range(0, 9);
      if (cls == 0) return $urandom;
      if (cls == 1) return $urandom_range(0, DIRECT_SLOTS - 1);
      lvl  = (cls == 9) ? INDIRECT_DEPTH : (cls - 2) % INDIRECT_DEPTH;
      base = 64'(DIRECT_SLOTS);
      span = 64'd1 << ish;
      for (i = 0; i < lvl; i++) begin
         base = base + span;
         span = span << ish;
      end
      if (base > 64'hFFFF_FFFF) return $urandom;
      limit = 64'h1_0000_0000 - base;
      if (lvl < INDIRECT_DEPTH && span < limit) limit = span;
      edge_roll = $urandom_range(0, 3);
      if (edge_roll == 0) off = 64'd0;
      else if (edge_roll == 1) off = limit - 64'd1;
      else off = {$urandom, $urandom} % limit;
      v = base + off;
      return v[LBLK_W-1:0];
   endfunction

   // Filler items: random loads (zero now and then, to make holes), unused
   // actions and words that may arrive with no walk in flight.
   task automatic send_noise();
      int unsigned pick;
      pick = $urandom_range(0, 3);
      case (pick)
         0, 1: send_item(ACT_LOAD, SLOT_W'($urandom_range(0, 15)),
                         ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom, $urandom);
         2: send_item(ACT_NONE, SLOT_W'($urandom), $urandom, $urandom);
         default: send_item(ACT_WORD, SLOT_W'($urandom), $urandom, $urandom);
      endcase
   endtask

   // Response side: hold ready low for a drawn wait after each transfer.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else if (rsp_valid && rsp_ready) begin
         hold_draw = draw_gap();
         rsp_hold  <= hold_draw;
         rsp_ready <= (hold_draw == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each result transfer with the oldest due result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result: kind %0d addr %h block %h", $time,
                     rsp_kind, rsp_read_address, rsp_physical_block);
            fails++;
         end else begin
            got = due_results.pop_front();
            if (rsp_kind !== got.kind) begin
               $display("%0t: kind mismatch: expected %0d actual %0d", $time, got.kind,
                        rsp_kind);
               fails++;
            end
            if (rsp_read_address !== got.addr) begin
               $display("%0t: read_address mismatch: expected %h actual %h", $time,
                        got.addr, rsp_read_address);
               fails++;
            end
            if (rsp_physical_block !== got.blk) begin
               $display("%0t: physical_block mismatch: expected %h actual %h", $time,
                        got.blk, rsp_physical_block);
               fails++;
            end
         end
      end
   end

   // Direct slots at both ends of the direct range, a load past the table, and the first
   // single-indirect block while its root is still zero (a hole).
   task automatic test_direct_pointers();
      send_item(ACT_LOAD, 4'd0, 32'hFFFF_FFFF, 32'd0);
      send_item(ACT_LOAD, 4'd11, 32'h5A5A_A5A5, 32'd0);
      send_item(ACT_LOAD, 4'd15, 32'h1234_5678, 32'hFFFF_FFFF);
      send_item(ACT_START, 4'd0, 32'd0, 32'd0);
      send_item(ACT_START, 4'hF, 32'hFFFF_FFFF, 32'd11);
      send_item(ACT_START, 4'd0, 32'd0, 32'd12);
   endtask

   // One walk per level at 1 KiB blocks, a zero word mid-walk, and a block past
   // the triple range.
   task automatic test_indirect_walks();
      send_item(ACT_LOAD, 4'd12, 32'h0000_0100, 32'd0);
      send_item(ACT_LOAD, 4'd13, 32'hFFFF_FFFF, 32'd0);
      send_item(ACT_LOAD, 4'd14, 32'h0000_0001, 32'd0);
      // single: first block
      send_item(ACT_START, 4'd0, 32'd0, 32'd12);
      send_item(ACT_WORD, 4'd0, 32'hFFFF_FFFF, 32'd0);
      // double: last block, largest root
      send_item(ACT_START, 4'd0, 32'd0, 32'd12 + 32'd256 + 32'd65535);
      send_item(ACT_WORD, 4'd0, 32'h0000_0022, 32'd0);
      send_item(ACT_WORD, 4'd0, 32'h0000_0000, 32'd0);
      // triple: first block, zero pointer on the way
      send_item(ACT_START, 4'd0, 32'd0, 32'd12 + 32'd256 + 32'd65536);
      send_item(ACT_WORD, 4'd0, 32'd0, 32'd0);
      send_item(ACT_START, 4'd0, 32'd0, 32'hFFFF_FFFF);
   endtask

   // Stray word, unused action, a load during a walk and a restart mid-walk.
   task automatic test_walk_interrupts();
      send_item(ACT_WORD, 4'd3, 32'hDEAD_BEEF, 32'd0);
      send_item(ACT_NONE, 4'd5, 32'h0F0F_0F0F, 32'd12);
      send_item(ACT_START, 4'd0, 32'd0, 32'd12 + 32'd256 + 32'd65536 + 32'd4660);
      send_item(ACT_LOAD, 4'd14, 32'd0, 32'd0);
      send_item(ACT_WORD, 4'd0, 32'd7, 32'd0);
      send_item(ACT_START, 4'd0, 32'd0, 32'd20);
      send_item(ACT_WORD, 4'd0, 32'd9, 32'd0);
   endtask

   // Change the block size between the two reads of a double walk.
   task automatic test_shift_change_mid_walk();
      write_block_shift(5'd10);
      send_item(ACT_START, 4'd0, 32'd0, 32'd12 + 32'd256 + 32'd1000);
      write_block_shift(5'd13);
      send_item(ACT_WORD, 4'd0, 32'd5, 32'd0);
      send_item(ACT_WORD, 4'd0, 32'd6, 32'd0);
   endtask

   // Random phases, one block size each (clamped values at both ends too).
   // Mostly complete walks with random words; some restarts and noise mixed in.
   task automatic test_random_mapping();
      logic [SHIFT_W-1:0] shifts [PHASE_COUNT];
      int unsigned        p, k, sent, roll;
      shifts = '{5'd10, 5'd16, 5'd0, 5'd31, 5'd12, 5'd14, 5'd11, 5'd13, 5'd15, 5'd9};
      for (p = 0; p < PHASE_COUNT; p++) begin
         write_block_shift(shifts[p]);
         no_idle = (p % 4 == 3);
         for (k = 0; k < INDIRECT_DEPTH; k++)
            send_item(ACT_LOAD, SLOT_W'(DIRECT_SLOTS + k), $urandom | 32'd1, $urandom);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            roll = $urandom_range(0, 99);
            if (walk_on) begin
               if (roll < 85)
                  send_item(ACT_WORD, SLOT_W'($urandom), (roll < 9) ? 32'd0 : $urandom,
                            $urandom);
               else if (roll < 92)
                  send_item(ACT_START, SLOT_W'($urandom), $urandom, pick_logical_block());
               else
                  send_noise();
            end else begin
               if (roll < 70)
                  send_item(ACT_START, SLOT_W'($urandom), $urandom, pick_logical_block());
               else
                  send_noise();
            end
            sent++;
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      int unsigned guard;
      for (int i = 0; i < TABLE_DEPTH; i++) ptr_slots[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_direct_pointers();
      test_indirect_walks();
      test_walk_interrupts();
      test_shift_change_mid_walk();
      test_random_mapping();

      // Drain: wait for due results with a bound, then a few spare cycles to
      // catch any extra result.
      req_valid <= 1'b0;
      guard = 0;
      while (due_results.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (due_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, due_results.size());
         fails++;
      end

      if (fails == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Hard stop, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/ibmw_pkg.sv
rtl/ibmw_ptr_mem.sv
rtl/ibmw_decode.sv
rtl/ibmw_walk.sv
rtl/indirect_block_map_walker.sv
tb/indirect_block_map_walker_tb.sv
